FILE: sv/ldcu_pkg.sv
// Shared package for the Lorentz-dispersive cell update block.
// Holds widths, command codes, the controller/datapath interface structs and helpers.
// Depends on nothing.
`default_nettype none
package ldcu_pkg;

  localparam int SLOTS_DEF        = 4096;
  localparam int MATERIALS_DEF    = 8;
  localparam int POLE_ENTRIES_DEF = 16;
  localparam int MAX_POLES_DEF    = 4;

  localparam int DATA_W  = 32;
  localparam int COEF_W  = 33;
  localparam int WIDE_W  = 48;
  localparam int PART_W  = 50;
  localparam int PROD_W  = 81;
  localparam int FRAC_SH = 28;

  localparam logic signed [COEF_W-1:0] ONE_Q28    = 33'sd268435456;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 81'sd134217728;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_POLE   = 2'd1;
  localparam logic [1:0] CMD_MAT    = 2'd2;

  localparam logic [1:0] DIG_HI  = 2'd0;
  localparam logic [1:0] DIG_MID = 2'd1;
  localparam logic [1:0] DIG_LO  = 2'd2;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    MUL_A1 = 3'd0,
    MUL_Z1 = 3'd1,
    MUL_C1 = 3'd2,
    MUL_C2 = 3'd3,
    MUL_C3 = 3'd4,
    MUL_A2 = 3'd5,
    MUL_Z2 = 3'd6,
    MUL_G2 = 3'd7
  } mul_op_t;

  typedef struct packed {
    logic      clr_we;
    logic      take;
    logic      ld_pole;
    logic      ld_mat;
    logic      axis_next;
    logic      walk_start;
    logic      walk_next;
    logic      rd_prev;
    logic      rd_pole;
    logic      mul_ld;
    logic      mul_go;
    logic [1:0] mul_dig;
    mul_op_t   mul_op;
    logic      mul_acc;
    logic      sum_clr;
    logic      jsum_clr;
    logic      e_fin;
    logic      j_wr;
    logic      prev_wr;
    logic      out_load;
  } ldcu_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic no_poles;
    logic last_pole;
    logic last_axis;
  } ldcu_stat_t;

  // Remainder of a 12-bit value by a constant, by binary long division.
  function automatic logic [11:0] reduce_mod(input logic [11:0] v, input int unsigned m);
    logic [11:0] r;
    r = v;
    for (int k = 11; k >= 0; k--) begin
      if (((m << k) <= 32'd4095) && (32'(r) >= (m << k))) begin
        r = r - 12'(m << k);
      end
    end
    return r;
  endfunction

  // Clip to the signed 32-bit range; the top bit reports a clip.
  function automatic logic [DATA_W:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > 48'sd2147483647) begin
      r = {1'b1, 32'h7fffffff};
    end else if (v < -48'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/lorentz_dispersive_cell_update.sv
// Top level of the Lorentz-dispersive cell update: controller plus datapath.
// Uses ldcu_pkg, ldcu_ctrl and ldcu_dp.
//
// After reset the block sweeps its field and current memories to zero, one slot per
// cycle, and takes no item until the sweep is done. It works on one item at a time.
// A load command or an unused command code also holds the block until its result is
// loaded. An update runs each of the three axes through a pole-sum pass, three
// coefficient products and a current-update pass, and every product goes through one
// shared digit-serial multiplier as a load step, a pass for each of its high, middle
// and low digits and an accumulate step. The next item may be accepted while the
// previous result still waits in the output register.
`default_nettype none
module lorentz_dispersive_cell_update import ldcu_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int MATERIALS    = MATERIALS_DEF,
  parameter int POLE_ENTRIES = POLE_ENTRIES_DEF,
  parameter int MAX_POLES    = MAX_POLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_material,
  input  logic [3:0]         in_pole_entry,
  input  logic [2:0]         in_pole_count,
  input  logic [11:0]        in_cell_slot,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  input  logic signed [31:0] in_value_c,
  input  logic signed [31:0] in_curl_x,
  input  logic signed [31:0] in_curl_y,
  input  logic signed [31:0] in_curl_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_e_x,
  output logic signed [31:0] out_new_e_y,
  output logic signed [31:0] out_new_e_z,
  output logic               out_saturated
);

  ldcu_cmd_t  cmd;
  ldcu_stat_t stat;

  ldcu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ldcu_dp #(
    .SLOTS        (SLOTS),
    .MATERIALS    (MATERIALS),
    .POLE_ENTRIES (POLE_ENTRIES),
    .MAX_POLES    (MAX_POLES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_material   (in_material),
    .in_pole_entry (in_pole_entry),
    .in_pole_count (in_pole_count),
    .in_cell_slot  (in_cell_slot),
    .in_value_a    (in_value_a),
    .in_value_b    (in_value_b),
    .in_value_c    (in_value_c),
    .in_curl_x     (in_curl_x),
    .in_curl_y     (in_curl_y),
    .in_curl_z     (in_curl_z),
    .cmd           (cmd),
    .stat          (stat),
    .out_new_e_x   (out_new_e_x),
    .out_new_e_y   (out_new_e_y),
    .out_new_e_z   (out_new_e_z),
    .out_saturated (out_saturated)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> !in_ready)
    else $error("Input was ready right after a transfer was taken.");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("Loaded result was not presented.");

  a_acc_after_digit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_acc |-> $past(cmd.mul_go))
    else $error("Product accumulated without a completed digit pass.");

  a_exclusive_writes: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_we, cmd.take, cmd.j_wr, cmd.prev_wr, cmd.mul_go}))
    else $error("Conflicting datapath commands in one cycle.");

endmodule
`default_nettype wire

FILE: sv/ldcu_ctrl.sv
// Sequencing state machine for the Lorentz-dispersive cell update.
// Drives the datapath through command and status structs; uses ldcu_pkg.
`default_nettype none
module ldcu_ctrl import ldcu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  output logic       out_valid,
  input  logic       out_ready,
  input  ldcu_stat_t stat,
  output ldcu_cmd_t  cmd
);

  typedef enum logic [18:0] {
    S_CLEAR = 19'h00001,
    S_IDLE  = 19'h00002,
    S_LDP   = 19'h00004,
    S_LDM   = 19'h00008,
    S_AXIS  = 19'h00010,
    S_P1_RD = 19'h00020,
    S_P1_A  = 19'h00040,
    S_P1_Z  = 19'h00080,
    S_E_C1  = 19'h00100,
    S_E_C2  = 19'h00200,
    S_E_C3  = 19'h00400,
    S_E_FIN = 19'h00800,
    S_P2_RD = 19'h01000,
    S_P2_A  = 19'h02000,
    S_P2_Z  = 19'h04000,
    S_P2_G  = 19'h08000,
    S_P2_WR = 19'h10000,
    S_PWR   = 19'h20000,
    S_FIN   = 19'h40000
  } state_t;

  localparam logic [2:0] DIG_ACC = 3'd4;

  state_t     state_r, state_nxt;
  logic [2:0] dig_r, dig_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_mul, walk_after;
  mul_op_t    op;
  state_t     after_mul;

  always_comb begin
    state_nxt  = state_r;
    dig_nxt    = dig_r;
    cmd        = '0;
    is_mul     = 1'b0;
    walk_after = 1'b0;
    op         = MUL_A1;
    after_mul  = S_IDLE;
    in_ready   = (state_r == S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (in_command)
            CMD_UPDATE: state_nxt = S_AXIS;
            CMD_POLE:   state_nxt = S_LDP;
            CMD_MAT:    state_nxt = S_LDM;
            default:    state_nxt = S_FIN;
          endcase
        end
      end
      S_LDP: begin
        cmd.ld_pole = 1'b1;
        state_nxt   = S_FIN;
      end
      S_LDM: begin
        cmd.ld_mat = 1'b1;
        state_nxt  = S_FIN;
      end
      S_AXIS: begin
        cmd.rd_prev    = 1'b1;
        cmd.sum_clr    = 1'b1;
        cmd.walk_start = 1'b1;
        state_nxt      = stat.no_poles ? S_E_C1 : S_P1_RD;
      end
      S_P1_RD: begin
        cmd.rd_pole = 1'b1;
        state_nxt   = S_P1_A;
      end
      S_P1_A: begin
        is_mul    = 1'b1;
        op        = MUL_A1;
        after_mul = S_P1_Z;
      end
      S_P1_Z: begin
        is_mul = 1'b1;
        op     = MUL_Z1;
        if (stat.last_pole) begin
          after_mul = S_E_C1;
        end else begin
          after_mul  = S_P1_RD;
          walk_after = 1'b1;
        end
      end
      S_E_C1: begin
        is_mul    = 1'b1;
        op        = MUL_C1;
        after_mul = S_E_C2;
      end
      S_E_C2: begin
        is_mul    = 1'b1;
        op        = MUL_C2;
        after_mul = S_E_C3;
      end
      S_E_C3: begin
        is_mul    = 1'b1;
        op        = MUL_C3;
        after_mul = S_E_FIN;
      end
      S_E_FIN: begin
        cmd.e_fin      = 1'b1;
        cmd.jsum_clr   = 1'b1;
        cmd.walk_start = 1'b1;
        state_nxt      = stat.no_poles ? S_PWR : S_P2_RD;
      end
      S_P2_RD: begin
        cmd.rd_pole = 1'b1;
        state_nxt   = S_P2_A;
      end
      S_P2_A: begin
        is_mul    = 1'b1;
        op        = MUL_A2;
        after_mul = S_P2_Z;
      end
      S_P2_Z: begin
        is_mul    = 1'b1;
        op        = MUL_Z2;
        after_mul = S_P2_G;
      end
      S_P2_G: begin
        is_mul    = 1'b1;
        op        = MUL_G2;
        after_mul = S_P2_WR;
      end
      S_P2_WR: begin
        cmd.j_wr     = 1'b1;
        cmd.jsum_clr = 1'b1;
        if (stat.last_pole) begin
          state_nxt = S_PWR;
        end else begin
          cmd.walk_next = 1'b1;
          state_nxt     = S_P2_RD;
        end
      end
      S_PWR: begin
        cmd.prev_wr = 1'b1;
        if (stat.last_axis) begin
          state_nxt = S_FIN;
        end else begin
          cmd.axis_next = 1'b1;
          state_nxt     = S_AXIS;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (is_mul) begin
      cmd.mul_op = op;
      if (dig_r == DIG_ACC) begin
        cmd.mul_acc   = 1'b1;
        cmd.walk_next = walk_after;
        dig_nxt       = '0;
        state_nxt     = after_mul;
      end else begin
        dig_nxt = dig_r + 3'd1;
        if (dig_r == 3'd0) begin
          cmd.mul_ld = 1'b1;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_dig = 2'(dig_r - 3'd1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: sv/ldcu_dp.sv
// Datapath of the Lorentz-dispersive cell update: coefficient tables, field and
// current memories, the digit-serial multiplier and the accumulators. Uses ldcu_pkg.
`default_nettype none
module ldcu_dp import ldcu_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int MATERIALS    = MATERIALS_DEF,
  parameter int POLE_ENTRIES = POLE_ENTRIES_DEF,
  parameter int MAX_POLES    = MAX_POLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_material,
  input  logic [3:0]         in_pole_entry,
  input  logic [2:0]         in_pole_count,
  input  logic [11:0]        in_cell_slot,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  input  logic signed [31:0] in_value_c,
  input  logic signed [31:0] in_curl_x,
  input  logic signed [31:0] in_curl_y,
  input  logic signed [31:0] in_curl_z,
  input  ldcu_cmd_t          cmd,
  output ldcu_stat_t         stat,
  output logic signed [31:0] out_new_e_x,
  output logic signed [31:0] out_new_e_y,
  output logic signed [31:0] out_new_e_z,
  output logic               out_saturated
);

  localparam int SW = $clog2(SLOTS);
  localparam int MW = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;
  localparam int PW = (POLE_ENTRIES > 1) ? $clog2(POLE_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_POLES + 1);

  logic signed [DATA_W-1:0] alpha_t [POLE_ENTRIES];
  logic signed [DATA_W-1:0] zeta_t  [POLE_ENTRIES];
  logic signed [DATA_W-1:0] gamma_t [POLE_ENTRIES];
  logic signed [DATA_W-1:0] c1_t    [MATERIALS];
  logic signed [DATA_W-1:0] c2_t    [MATERIALS];
  logic signed [DATA_W-1:0] c3_t    [MATERIALS];
  logic [PW-1:0]            first_t [MATERIALS];
  logic [CW-1:0]            cnt_t   [MATERIALS];

  logic [2:0][DATA_W-1:0] prev_mem [SLOTS];
  logic [2:0][DATA_W-1:0] cur_mem  [SLOTS];
  logic [2:0][DATA_W-1:0] old_mem  [SLOTS];

  logic [MW-1:0]            mat_r;
  logic [PW-1:0]            pe_r;
  logic [CW-1:0]            pc_r;
  logic [SW-1:0]            d_r;
  logic signed [DATA_W-1:0] va_r, vb_r, vc_r, cx_r, cy_r, cz_r;

  logic [SW-1:0] clr_r, s_r;
  logic [PW-1:0] p_r;
  logic [CW-1:0] i_r;
  axis_t         axis_r;

  logic signed [DATA_W-1:0] prev_rd_r, cur_rd_r, old_rd_r;
  logic signed [COEF_W-1:0] coef_r, coef_sel;
  logic signed [WIDE_W-1:0] x_r, x_sel;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, shifted, rnd;
  logic signed [16:0]       dsel;
  logic signed [PART_W-1:0] part;
  logic signed [WIDE_W-1:0] mres, sum_r, esum_r, jsum_r, de_r;
  logic signed [DATA_W-1:0] e_lane, curl_lane;
  logic [DATA_W:0]          e_sat, j_sat;
  logic [2:0][DATA_W-1:0]   res_r;
  logic                     flag_r;

  always_comb begin
    unique case (axis_r)
      AX_X: begin
        e_lane    = va_r;
        curl_lane = cx_r;
      end
      AX_Y: begin
        e_lane    = vb_r;
        curl_lane = cy_r;
      end
      default: begin
        e_lane    = vc_r;
        curl_lane = cz_r;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.mul_op)
      MUL_A1: begin
        coef_sel = COEF_W'(alpha_t[p_r]) + ONE_Q28;
        x_sel    = WIDE_W'(cur_rd_r);
      end
      MUL_Z1, MUL_Z2: begin
        coef_sel = COEF_W'(zeta_t[p_r]);
        x_sel    = WIDE_W'(old_rd_r);
      end
      MUL_C1: begin
        coef_sel = COEF_W'(c1_t[mat_r]);
        x_sel    = WIDE_W'(prev_rd_r);
      end
      MUL_C2: begin
        coef_sel = COEF_W'(c2_t[mat_r]);
        x_sel    = WIDE_W'(e_lane);
      end
      MUL_C3: begin
        coef_sel = COEF_W'(c3_t[mat_r]);
        x_sel    = WIDE_W'(curl_lane) - ((sum_r + 48'sd1) >>> 1);
      end
      MUL_A2: begin
        coef_sel = COEF_W'(alpha_t[p_r]);
        x_sel    = WIDE_W'(cur_rd_r);
      end
      default: begin
        coef_sel = COEF_W'(gamma_t[p_r]);
        x_sel    = de_r;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.mul_dig)
      DIG_HI:  dsel = $signed({x_r[47], x_r[47:32]});
      DIG_MID: dsel = $signed({1'b0, x_r[31:16]});
      default: dsel = $signed({1'b0, x_r[15:0]});
    endcase
    part     = coef_r * dsel;
    shifted  = (cmd.mul_dig == DIG_HI) ? '0 : (prod_r <<< 16);
    rnd      = (cmd.mul_dig == DIG_LO) ? ROUND_HALF : '0;
    prod_nxt = shifted + PROD_W'(part) + rnd;
    mres     = $signed(prod_r[FRAC_SH+WIDE_W-1:FRAC_SH]);
    e_sat    = sat32(esum_r);
    j_sat    = sat32(jsum_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mat_r <= MW'(reduce_mod({9'd0, in_material}, MATERIALS));
      pe_r  <= PW'(reduce_mod({8'd0, in_pole_entry}, POLE_ENTRIES));
      pc_r  <= (in_pole_count > MAX_POLES) ? CW'(MAX_POLES) : CW'(in_pole_count);
      d_r   <= SW'(reduce_mod(in_cell_slot, SLOTS));
      va_r  <= in_value_a;
      vb_r  <= in_value_b;
      vc_r  <= in_value_c;
      cx_r  <= in_curl_x;
      cy_r  <= in_curl_y;
      cz_r  <= in_curl_z;
    end
    if (cmd.mul_ld) begin
      coef_r <= coef_sel;
      x_r    <= x_sel;
    end
    if (cmd.mul_go) begin
      prod_r <= prod_nxt;
    end
    if (cmd.sum_clr) begin
      sum_r  <= '0;
      esum_r <= '0;
    end else if (cmd.mul_acc && (cmd.mul_op == MUL_A1 || cmd.mul_op == MUL_Z1)) begin
      sum_r <= sum_r + mres;
    end else if (cmd.mul_acc && (cmd.mul_op == MUL_C1 || cmd.mul_op == MUL_C2 ||
                                 cmd.mul_op == MUL_C3)) begin
      esum_r <= esum_r + mres;
    end
    if (cmd.jsum_clr) begin
      jsum_r <= '0;
    end else if (cmd.mul_acc && (cmd.mul_op == MUL_A2 || cmd.mul_op == MUL_Z2 ||
                                 cmd.mul_op == MUL_G2)) begin
      jsum_r <= jsum_r + mres;
    end
    if (cmd.e_fin) begin
      res_r[axis_r] <= e_sat[DATA_W-1:0];
      de_r          <= WIDE_W'($signed(e_sat[DATA_W-1:0])) - WIDE_W'(prev_rd_r);
    end
    if (cmd.take) begin
      res_r <= '0;
    end
    if (cmd.out_load) begin
      out_new_e_x   <= $signed(res_r[AX_X]);
      out_new_e_y   <= $signed(res_r[AX_Y]);
      out_new_e_z   <= $signed(res_r[AX_Z]);
      out_saturated <= flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
      clr_r  <= '0;
      s_r    <= '0;
      p_r    <= '0;
      i_r    <= '0;
      axis_r <= AX_X;
    end else begin
      if (cmd.take) begin
        flag_r <= 1'b0;
      end else if ((cmd.e_fin && e_sat[DATA_W]) || (cmd.j_wr && j_sat[DATA_W])) begin
        flag_r <= 1'b1;
      end
      if (cmd.clr_we) begin
        clr_r <= clr_r + SW'(1);
      end
      if (cmd.take) begin
        axis_r <= AX_X;
      end else if (cmd.axis_next) begin
        unique case (axis_r)
          AX_X:    axis_r <= AX_Y;
          AX_Y:    axis_r <= AX_Z;
          default: axis_r <= AX_X;
        endcase
      end
      if (cmd.walk_start) begin
        s_r <= d_r;
        p_r <= first_t[mat_r];
        i_r <= '0;
      end else if (cmd.walk_next) begin
        s_r <= (s_r == SW'(SLOTS - 1)) ? '0 : s_r + SW'(1);
        p_r <= (p_r == PW'(POLE_ENTRIES - 1)) ? '0 : p_r + PW'(1);
        i_r <= i_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < POLE_ENTRIES; k++) begin
        alpha_t[k] <= '0;
        zeta_t[k]  <= '0;
        gamma_t[k] <= '0;
      end
      for (int k = 0; k < MATERIALS; k++) begin
        c1_t[k]    <= '0;
        c2_t[k]    <= '0;
        c3_t[k]    <= '0;
        first_t[k] <= '0;
        cnt_t[k]   <= '0;
      end
    end else begin
      if (cmd.ld_pole) begin
        alpha_t[pe_r] <= va_r;
        zeta_t[pe_r]  <= vb_r;
        gamma_t[pe_r] <= vc_r;
      end
      if (cmd.ld_mat) begin
        c1_t[mat_r]    <= va_r;
        c2_t[mat_r]    <= vb_r;
        c3_t[mat_r]    <= vc_r;
        first_t[mat_r] <= pe_r;
        cnt_t[mat_r]   <= pc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      prev_mem[clr_r] <= '0;
    end else if (cmd.prev_wr) begin
      prev_mem[d_r][axis_r] <= e_lane;
    end
    if (cmd.rd_prev) begin
      prev_rd_r <= $signed(prev_mem[d_r][axis_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      cur_mem[clr_r] <= '0;
    end else if (cmd.j_wr) begin
      cur_mem[s_r][axis_r] <= j_sat[DATA_W-1:0];
    end
    if (cmd.rd_pole) begin
      cur_rd_r <= $signed(cur_mem[s_r][axis_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      old_mem[clr_r] <= '0;
    end else if (cmd.j_wr) begin
      old_mem[s_r][axis_r] <= cur_rd_r;
    end
    if (cmd.rd_pole) begin
      old_rd_r <= $signed(old_mem[s_r][axis_r]);
    end
  end

  assign stat.clr_last  = (clr_r == SW'(SLOTS - 1));
  assign stat.no_poles  = (cnt_t[mat_r] == '0);
  assign stat.last_pole = ((CW + 1)'(i_r) + (CW + 1)'(1) == (CW + 1)'(cnt_t[mat_r]));
  assign stat.last_axis = (axis_r == AX_Z);

endmodule
`default_nettype wire

FILE: tb/lorentz_checker.sv
// Scoreboard for the Lorentz-dispersive cell update: watches both channels,
// predicts each result from its own copy of the tables and cell stores, and compares.
// Depends on ldcu_pkg for the command codes.
`timescale 1ns / 1ps
module lorentz_checker import ldcu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_material,
  input  logic [3:0]         in_pole_entry,
  input  logic [2:0]         in_pole_count,
  input  logic [11:0]        in_cell_slot,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  input  logic signed [31:0] in_value_c,
  input  logic signed [31:0] in_curl_x,
  input  logic signed [31:0] in_curl_y,
  input  logic signed [31:0] in_curl_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_new_e_x,
  input  logic signed [31:0] out_new_e_y,
  input  logic signed [31:0] out_new_e_z,
  input  logic               out_saturated,
  output int                 errors,
  output int                 pending,
  output int                 updates_seen,
  output int                 clipped_seen
);

  typedef struct {
    int ex;
    int ey;
    int ez;
    bit sat;
  } e_field_t;

  int pole_alpha [16];
  int pole_zeta  [16];
  int pole_gamma [16];
  int mat_c1     [8];
  int mat_c2     [8];
  int mat_c3     [8];
  int mat_first  [8];
  int mat_count  [8];
  int prev_e     [3][4096];
  int j_now      [3][4096];
  int j_old      [3][4096];

  e_field_t expected_e[$];

  initial begin
    errors = 0;
    updates_seen = 0;
    clipped_seen = 0;
    foreach (pole_alpha[i]) begin
      pole_alpha[i] = 0;
      pole_zeta[i] = 0;
      pole_gamma[i] = 0;
    end
    foreach (mat_c1[i]) begin
      mat_c1[i] = 0;
      mat_c2[i] = 0;
      mat_c3[i] = 0;
      mat_first[i] = 0;
      mat_count[i] = 0;
    end
    for (int a = 0; a < 3; a++) begin
      for (int s = 0; s < 4096; s++) begin
        prev_e[a][s] = 0;
        j_now[a][s] = 0;
        j_old[a][s] = 0;
      end
    end
  end

  assign pending = expected_e.size();

  // Q4.28 coefficient times Q16.16 data, rounded to nearest with ties upward.
  function automatic longint coef_mul(longint c, longint x);
    logic signed [127:0] wc;
    logic signed [127:0] wx;
    logic signed [127:0] p;
    wc = c;
    wx = x;
    p = wc * wx + (128'sd1 <<< 27);
    return longint'(p >>> 28);
  endfunction

  function automatic int clip32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  function automatic int advance_axis(int ax, int d, int m, longint e_in, longint curl,
                                      inout bit flag);
    longint pole_sum;
    longint inner;
    longint e_raw;
    longint de;
    longint jn;
    int e_out;
    int p;
    int s;
    int j;
    pole_sum = 0;
    for (int i = 0; i < mat_count[m]; i++) begin
      p = (mat_first[m] + i) % 16;
      s = (d + i) % 4096;
      pole_sum += coef_mul(longint'(pole_alpha[p]) + (64'sd1 <<< 28), j_now[ax][s]);
      pole_sum += coef_mul(pole_zeta[p], j_old[ax][s]);
    end
    inner = curl - ((pole_sum + 1) >>> 1);
    e_raw = coef_mul(mat_c1[m], prev_e[ax][d]) + coef_mul(mat_c2[m], e_in)
          + coef_mul(mat_c3[m], inner);
    e_out = clip32(e_raw, flag);
    de = longint'(e_out) - longint'(prev_e[ax][d]);
    for (int i = 0; i < mat_count[m]; i++) begin
      p = (mat_first[m] + i) % 16;
      s = (d + i) % 4096;
      j = j_now[ax][s];
      jn = coef_mul(pole_alpha[p], j) + coef_mul(pole_zeta[p], j_old[ax][s])
         + coef_mul(pole_gamma[p], de);
      j_now[ax][s] = clip32(jn, flag);
      j_old[ax][s] = j;
    end
    prev_e[ax][d] = int'(e_in);
    return e_out;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    e_field_t r;
    if (rst_n && in_valid && in_ready) begin
      r = '{0, 0, 0, 1'b0};
      case (in_command)
        CMD_UPDATE: begin
          r.ex = advance_axis(0, in_cell_slot, in_material, in_value_a, in_curl_x, r.sat);
          r.ey = advance_axis(1, in_cell_slot, in_material, in_value_b, in_curl_y, r.sat);
          r.ez = advance_axis(2, in_cell_slot, in_material, in_value_c, in_curl_z, r.sat);
          updates_seen++;
          if (r.sat) clipped_seen++;
        end
        CMD_POLE: begin
          pole_alpha[in_pole_entry] = in_value_a;
          pole_zeta[in_pole_entry] = in_value_b;
          pole_gamma[in_pole_entry] = in_value_c;
        end
        CMD_MAT: begin
          mat_c1[in_material] = in_value_a;
          mat_c2[in_material] = in_value_b;
          mat_c3[in_material] = in_value_c;
          mat_first[in_material] = in_pole_entry;
          mat_count[in_material] = (in_pole_count > 4) ? 4 : in_pole_count;
        end
        default: ;
      endcase
      expected_e.push_back(r);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_e.size() == 0) begin
        report("result transfer with nothing expected", out_new_e_x, 0);
      end else begin
        r = expected_e.pop_front();
        if (out_new_e_x !== r.ex) report("new_e_x", out_new_e_x, r.ex);
        if (out_new_e_y !== r.ey) report("new_e_y", out_new_e_y, r.ey);
        if (out_new_e_z !== r.ez) report("new_e_z", out_new_e_z, r.ez);
        if (out_saturated !== r.sat) report("saturated", out_saturated, r.sat);
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the Lorentz-dispersive cell update testbench: clock, reset, stimulus and verdict.
// Depends on ldcu_pkg, lorentz_dispersive_cell_update and lorentz_checker.
`timescale 1ns / 1ps
module testbench;
  import ldcu_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT = 4000000;
  localparam int ONE = 268435456;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_command;
  logic [2:0]         in_material;
  logic [3:0]         in_pole_entry;
  logic [2:0]         in_pole_count;
  logic [11:0]        in_cell_slot;
  logic signed [31:0] in_value_a;
  logic signed [31:0] in_value_b;
  logic signed [31:0] in_value_c;
  logic signed [31:0] in_curl_x;
  logic signed [31:0] in_curl_y;
  logic signed [31:0] in_curl_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_new_e_x;
  logic signed [31:0] out_new_e_y;
  logic signed [31:0] out_new_e_z;
  logic               out_saturated;
  int                 errors;
  int                 pending;
  int                 updates_seen;
  int                 clipped_seen;
  int                 cycles;
  int                 stall_phase;

  lorentz_dispersive_cell_update dut (.*);
  lorentz_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    cycles = 0;
    out_ready = 1'b0;
    stall_phase = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lorentz_dispersive_cell_update: mismatch");
      $finish;
    end
  end

  // The receiver alternates between runs with no stall and runs of random stalls.
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_phase <= $urandom_range(1, 400);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    if (stall_phase > 200) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [31:0] pick(int narrow);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 2 * narrow) - narrow;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(logic [1:0] cmd, logic [2:0] m, logic [3:0] pe, logic [2:0] pc,
                      logic [11:0] slot, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                      logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    in_command = cmd;
    in_material = m;
    in_pole_entry = pe;
    in_pole_count = pc;
    in_cell_slot = slot;
    in_value_a = a;
    in_value_b = b;
    in_value_c = c;
    in_curl_x = cx;
    in_curl_y = cy;
    in_curl_z = cz;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_item();
    int sel;
    logic [11:0] slot;
    sel = $urandom_range(0, 99);
    slot = ($urandom_range(0, 9) == 0) ? 12'($urandom) :
           ($urandom_range(0, 3) == 0) ? 12'($urandom_range(4090, 4095)) :
           12'($urandom_range(0, 31));
    if (sel < 72) begin
      send(CMD_UPDATE, 3'($urandom), 4'($urandom), 3'($urandom), slot, pick(1 << 24),
           pick(1 << 24), pick(1 << 24), pick(1 << 22), pick(1 << 22), pick(1 << 22));
    end else if (sel < 84) begin
      send(CMD_POLE, 3'($urandom), 4'($urandom), 3'($urandom), 12'($urandom), pick(ONE),
           pick(ONE / 2), pick(ONE / 4), $urandom, $urandom, $urandom);
    end else if (sel < 94) begin
      send(CMD_MAT, 3'($urandom), 4'($urandom),
           ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2)),
           12'($urandom), pick(ONE), pick(ONE), pick(ONE / 8), $urandom, $urandom,
           $urandom);
    end else begin
      send(($urandom_range(0, 1) == 0) ? CMD_UNUSED : CMD_UPDATE, 3'($urandom),
           4'($urandom), 3'($urandom), 12'($urandom), $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_UPDATE;
    in_material = '0;
    in_pole_entry = '0;
    in_pole_count = '0;
    in_cell_slot = '0;
    in_value_a = '0;
    in_value_b = '0;
    in_value_c = '0;
    in_curl_x = '0;
    in_curl_y = '0;
    in_curl_z = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Empty-table update, pole and material loads at extremes, updates, an unused code.
    send(CMD_UPDATE, 3'd0, 4'd0, 3'd0, 12'd0, 32'sh7fffffff, 32'sh80000000, 32'sd65536,
         32'sd1, -32'sd1, 32'sd0);
    send(CMD_POLE, 3'd0, 4'd0, 3'd0, 12'd0, ONE / 2, -ONE / 4, ONE / 8, 0, 0, 0);
    send(CMD_POLE, 3'd0, 4'd1, 3'd0, 12'd0, -ONE / 3, ONE / 5, -ONE / 16, 0, 0, 0);
    send(CMD_POLE, 3'd7, 4'd15, 3'd7, 12'hfff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
         32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send(CMD_POLE, 3'd0, 4'd14, 3'd0, 12'd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
         0, 0, 0);
    send(CMD_MAT, 3'd0, 4'd0, 3'd2, 12'd0, ONE, ONE / 2, ONE / 4, 0, 0, 0);
    send(CMD_MAT, 3'd1, 4'd15, 3'd7, 12'd0, ONE / 2, ONE, -ONE / 2, 0, 0, 0);
    send(CMD_MAT, 3'd7, 4'd3, 3'd0, 12'd0, ONE, ONE, ONE, 0, 0, 0);
    send(CMD_MAT, 3'd2, 4'd13, 3'd4, 12'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
         0, 0, 0);
    send(CMD_MAT, 3'd3, 4'd14, 3'd5, 12'd0, ONE, 0, ONE, 0, 0, 0);
    send(CMD_UPDATE, 3'd0, 4'd0, 3'd0, 12'd0, 32'sd65536, -32'sd131072, 32'sd3, 32'sd100,
         32'sd200, -32'sd300);
    send(CMD_UPDATE, 3'd0, 4'd0, 3'd0, 12'd0, 32'sh7fffffff, 32'sh80000000, 32'sd0,
         32'sh7fffffff, 32'sh80000000, 32'sd1);
    send(CMD_UPDATE, 3'd1, 4'd0, 3'd0, 12'hfff, 32'sd70000, 32'sd80000, -32'sd90000,
         32'sd5000, -32'sd5000, 32'sd0);
    send(CMD_UPDATE, 3'd1, 4'd0, 3'd0, 12'hffe, 32'sh80000000, 32'sh7fffffff, 32'sd1,
         32'sh80000000, 32'sh7fffffff, -32'sd1);
    send(CMD_UPDATE, 3'd7, 4'd0, 3'd0, 12'd100, 32'sd12345, -32'sd54321, 32'sd999,
         32'sd1, 32'sd2, 32'sd3);
    send(CMD_UPDATE, 3'd2, 4'd0, 3'd0, 12'd7, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
         32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send(CMD_UPDATE, 3'd2, 4'd0, 3'd0, 12'd7, 32'sh80000000, 32'sd0, 32'sh7fffffff,
         32'sd0, 32'sd0, 32'sd0);
    send(CMD_UPDATE, 3'd3, 4'd0, 3'd0, 12'hffd, 32'sd40000, 32'sd40000, 32'sd40000,
         32'sd40000, 32'sd40000, 32'sd40000);
    send(CMD_UNUSED, 3'd5, 4'd9, 3'd6, 12'd9, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom);
    send(CMD_UPDATE, 3'd0, 4'd0, 3'd0, 12'd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1);

    sent = 0;
    while (sent < 1630) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst; k++) begin
        random_item();
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    $display("Sent %0d items after the directed set; %0d cell updates checked, %0d clipped.",
             sent, updates_seen, clipped_seen);
    $display("Covered pole and material loads, wrapped pole walks and idle command codes.");
    if (errors == 0 && pending == 0) begin
      $display("lorentz_dispersive_cell_update: match");
    end else begin
      $display("lorentz_dispersive_cell_update: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ldcu_pkg.sv
sv/ldcu_ctrl.sv
sv/ldcu_dp.sv
sv/lorentz_dispersive_cell_update.sv
tb/lorentz_checker.sv
tb/testbench.sv
